// ===== design/hmg_pkg.sv =====
// Shared types, widths and position helpers for the Hamming encoder and checker.
// Used by design/hamming_encode_and_syndrome.sv through scoped names.
package hmg_pkg;

   localparam int MAX_DATA_BITS = 26;
   localparam int CW_WIDTH      = 31;
   localparam int POS_WIDTH     = 5;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [POS_WIDTH-1:0] DATA_BITS_RESET = 5'd4;
   localparam logic                 ACT_ENCODE      = 1'b0;
   localparam logic                 ACT_CHECK       = 1'b1;
   localparam logic                 REG_DATA_BITS   = 1'b0;

   typedef struct packed {
      logic                 action;
      logic [CW_WIDTH-1:0]  word;
      logic [POS_WIDTH-1:0] n;
   } item_type;

   // Codeword length for k data bits: k plus the least r with 2^r >= k + r + 1.
   function automatic logic [POS_WIDTH-1:0] code_length(input logic [POS_WIDTH-1:0] k);
      logic [6:0] r;
      logic       done;
      r    = 7'd0;
      done = 1'b0;
      for (int t = 0; t < 7; t++) begin
         if (!done) begin
            if ((7'd1 << t) >= 7'(k) + 7'(t) + 7'd1) begin
               r    = 7'(t);
               done = 1'b1;
            end
         end
      end
      return POS_WIDTH'(7'(k) + r);
   endfunction

   function automatic logic is_pow2(input int p);
      return (p != 0) && ((p & (p - 1)) == 0);
   endfunction

   // Data bit that lands at position p (p not a power of two).
   function automatic int data_index(input int p);
      int count;
      count = 0;
      for (int t = 0; t < POS_WIDTH; t++) begin
         if ((1 << t) <= p) count++;
      end
      return p - 1 - count;
   endfunction

   // Positions whose index has bit t set, bit0 = position 1.
   function automatic logic [CW_WIDTH-1:0] pos_mask(input int t);
      logic [CW_WIDTH-1:0] m;
      m = '0;
      for (int p = 1; p <= CW_WIDTH; p++) begin
         m[p-1] = ((p >> t) & 1) != 0;
      end
      return m;
   endfunction

endpackage

// ===== design/hamming_encode_and_syndrome.sv =====
// Even-parity Hamming encoder and syndrome checker, four-stage pipeline.
// Depends on design/hmg_pkg.sv for widths, types and position helpers.
//
// Usage:
//   The req_ stream carries one transaction per codeword: req_tuser selects
//   encode (0) or check (1), req_tdata holds data bits or a received codeword.
//   The rsp_ stream returns one transaction per request with the codeword,
//   the syndrome and the codeword length. The csr_ APB port holds data_bits
//   at address 0; values of 0 act as 1 and values above 26 act as 26.
//   Throughput is one
//   transaction per cycle, set by the stage registers; each stage holds its
//   item while the next is full, so a stalled receiver fills the pipeline
//   and req_tready drops only when all four stages hold an item.
//   Stages: capture and length, position scatter and mask, parity trees,
//   parity insertion into the output register.
//   Reset is synchronous: it empties the pipeline and sets data_bits to 4.
//   data_bits must be written only while the pipeline is empty; the block does not enforce this.
module hamming_encode_and_syndrome (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [30:0] payload, [31] zero
   input  logic        req_tuser,  // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // [30:0] codeword, [35:31] syndrome, [40:36] total_bits
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = hmg_pkg::CW_WIDTH;
   localparam int PW = hmg_pkg::POS_WIDTH;

   logic [PW-1:0] data_bits_ff, data_bits_in;
   logic [PW-1:0] k_eff;

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic               v1_in, v2_in, v3_in, v4_in;
   hmg_pkg::item_type  s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic [PW-1:0]      syn3_ff, syn3_in;
   logic [CW-1:0]      cw4_ff, cw4_in;
   logic [PW-1:0]      syn4_ff, syn4_in;
   logic [PW-1:0]      n4_ff, n4_in;
   logic               load1, load2, load3, load4;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(32-PW){1'b0}}, data_bits_ff};

   always_comb begin
      data_bits_in = data_bits_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[2] == hmg_pkg::REG_DATA_BITS) begin
         data_bits_in = csr_pwdata[PW-1:0];
      end
   end

   always_comb begin
      k_eff = data_bits_ff;
      if (data_bits_ff == '0) k_eff = PW'(1);
      else if (data_bits_ff > PW'(hmg_pkg::MAX_DATA_BITS)) k_eff = PW'(hmg_pkg::MAX_DATA_BITS);
   end

   // Each stage loads when it is empty or its item moves on.
   assign load4      = !v4_ff || rsp_tready;
   assign load3      = !v3_ff || load4;
   assign load2      = !v2_ff || load3;
   assign load1      = !v1_ff || load2;
   assign req_tready = load1;

   assign v1_in = load1 ? (req_tvalid && req_tready) : v1_ff;
   assign v2_in = load2 ? v1_ff : v2_ff;
   assign v3_in = load3 ? v2_ff : v3_ff;
   assign v4_in = load4 ? v3_ff : v4_ff;

   // Stage 1: capture the item with its codeword length.
   always_comb begin
      s1_in.action = req_tuser;
      s1_in.word   = req_tdata[CW-1:0];
      s1_in.n      = hmg_pkg::code_length(k_eff);
   end

   // Stage 2: on encode scatter data bits past the parity positions; then clear
   // every position above the codeword length.
   always_comb begin
      logic [CW-1:0] spread;
      logic [CW-1:0] len_mask;
      spread   = '0;
      len_mask = '0;
      for (int p = 1; p <= CW; p++) begin
         if (!hmg_pkg::is_pow2(p)) begin
            spread[p-1] = s1_ff.word[hmg_pkg::data_index(p)];
         end
         len_mask[p-1] = (PW'(p) <= s1_ff.n);
      end
      s2_in        = s1_ff;
      s2_in.word   = len_mask & ((s1_ff.action == hmg_pkg::ACT_CHECK) ? s1_ff.word : spread);
   end

   // Stage 3: XOR of the indices of all set positions, one tree per bit.
   always_comb begin
      s3_in = s2_ff;
      for (int t = 0; t < PW; t++) begin
         syn3_in[t] = ^(s2_ff.word & hmg_pkg::pos_mask(t));
      end
   end

   // Stage 4: on encode the syndrome bits become the parity bits; on check the syndrome passes with a zero codeword.
   always_comb begin
      logic [CW-1:0] par;
      par = '0;
      for (int t = 0; t < PW; t++) begin
         par[(1 << t) - 1] = syn3_ff[t];
      end
      n4_in = s3_ff.n;
      if (s3_ff.action == hmg_pkg::ACT_CHECK) begin
         cw4_in  = '0;
         syn4_in = syn3_ff;
      end else begin
         cw4_in  = s3_ff.word | par;
         syn4_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff <= hmg_pkg::DATA_BITS_RESET;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
      end else begin
         data_bits_ff <= data_bits_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) s1_ff <= s1_in;
      if (load2) s2_ff <= s2_in;
      if (load3) begin
         s3_ff   <= s3_in;
         syn3_ff <= syn3_in;
      end
      if (load4) begin
         cw4_ff  <= cw4_in;
         syn4_ff <= syn4_in;
         n4_ff   <= n4_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {7'd0, n4_ff, syn4_ff, cw4_ff};

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the Hamming encoder and syndrome checker.
// It uses hmg_pkg and hamming_encode_and_syndrome from design/ and has its own codeword predictor.
`timescale 1ns / 1ps

module tb;

   localparam int   CW_WIDTH      = hmg_pkg::CW_WIDTH;
   localparam int   POS_WIDTH     = hmg_pkg::POS_WIDTH;
   localparam int   CSR_ADDR_W    = hmg_pkg::CSR_ADDR_W;
   localparam int   MAX_DATA_BITS = hmg_pkg::MAX_DATA_BITS;
   localparam logic ACT_ENCODE    = hmg_pkg::ACT_ENCODE;
   localparam logic ACT_CHECK     = hmg_pkg::ACT_CHECK;

   localparam int ITEMS_PER_PHASE = 185;
   localparam int RANDOM_PHASES   = 10;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 10;
   localparam int DIRECTED_ROWS   = 24;
   localparam logic TYPED         = 1'b1;
   localparam logic PREDICTED     = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] DATA_BITS_ADDR =
      CSR_ADDR_W'(4 * hmg_pkg::REG_DATA_BITS);

   typedef struct packed {
      logic [CW_WIDTH-1:0]  cw;
      logic [POS_WIDTH-1:0] syn;
      logic [POS_WIDTH-1:0] len;
   } hm_result_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0] cfg;
      logic                 act;
      logic [CW_WIDTH-1:0]  pay;
      logic                 typed;
      hm_result_type        res;
   } probe_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [30:0] payload, [31] zero
   logic        req_tuser = 1'b0; // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [30:0] codeword, [35:31] syndrome, [40:36] total_bits
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [POS_WIDTH-1:0] data_bits_cfg = hmg_pkg::DATA_BITS_RESET;
   hm_result_type        pending_words[$];
   int                   mismatch_count = 0;
   int                   quiet_cycles = 0;
   bit                   steady = 1'b0;

   // Extremes and special cases: reset length, clamped lengths, full-length
   // codewords, single and double errors, a syndrome beyond the codeword.
   probe_type directed_rows [DIRECTED_ROWS] = '{
      '{5'd4,  ACT_ENCODE, 31'h0,        TYPED,     '{31'h0,        5'd0,  5'd7}},
      '{5'd4,  ACT_ENCODE, 31'hF,        TYPED,     '{31'h7F,       5'd0,  5'd7}},
      '{5'd4,  ACT_ENCODE, 31'h7FFFFFFF, TYPED,     '{31'h7F,       5'd0,  5'd7}},
      '{5'd4,  ACT_ENCODE, 31'h5,        PREDICTED, '{31'h0,        5'd0,  5'd0}},
      '{5'd4,  ACT_CHECK,  31'h7F,       TYPED,     '{31'h0,        5'd0,  5'd7}},
      '{5'd4,  ACT_CHECK,  31'h7FFFFFFF, TYPED,     '{31'h0,        5'd0,  5'd7}},
      '{5'd4,  ACT_CHECK,  31'h7E,       TYPED,     '{31'h0,        5'd1,  5'd7}},
      '{5'd4,  ACT_CHECK,  31'h40,       TYPED,     '{31'h0,        5'd7,  5'd7}},
      '{5'd4,  ACT_CHECK,  31'h3,        PREDICTED, '{31'h0,        5'd0,  5'd0}},
      '{5'd0,  ACT_ENCODE, 31'h1,        TYPED,     '{31'h7,        5'd0,  5'd3}},
      '{5'd0,  ACT_CHECK,  31'h7FFFFFFF, TYPED,     '{31'h0,        5'd0,  5'd3}},
      '{5'd1,  ACT_ENCODE, 31'h7FFFFFFE, TYPED,     '{31'h0,        5'd0,  5'd3}},
      '{5'd1,  ACT_CHECK,  31'h4,        TYPED,     '{31'h0,        5'd3,  5'd3}},
      '{5'd5,  ACT_CHECK,  31'hC0,       TYPED,     '{31'h0,        5'd15, 5'd9}},
      '{5'd5,  ACT_ENCODE, 31'h1F,       PREDICTED, '{31'h0,        5'd0,  5'd0}},
      '{5'd26, ACT_ENCODE, 31'h3FFFFFF,  TYPED,     '{31'h7FFFFFFF, 5'd0,  5'd31}},
      '{5'd26, ACT_ENCODE, 31'h7FFFFFFF, TYPED,     '{31'h7FFFFFFF, 5'd0,  5'd31}},
      '{5'd26, ACT_CHECK,  31'h7FFFFFFF, TYPED,     '{31'h0,        5'd0,  5'd31}},
      '{5'd26, ACT_CHECK,  31'h40000000, TYPED,     '{31'h0,        5'd31, 5'd31}},
      '{5'd26, ACT_ENCODE, 31'h2AAAAAA,  PREDICTED, '{31'h0,        5'd0,  5'd0}},
      '{5'd27, ACT_ENCODE, 31'h1,        PREDICTED, '{31'h0,        5'd0,  5'd0}},
      '{5'd31, ACT_CHECK,  31'h5,        PREDICTED, '{31'h0,        5'd0,  5'd0}},
      '{5'd11, ACT_ENCODE, 31'h7FF,      PREDICTED, '{31'h0,        5'd0,  5'd0}},
      '{5'd31, ACT_ENCODE, 31'h0,        TYPED,     '{31'h0,        5'd0,  5'd31}}
   };

   hamming_encode_and_syndrome DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // XOR of the indices of all set positions 1..n, bit 0 being position 1.
   function automatic int position_xor(input logic [CW_WIDTH-1:0] word, input int n);
      int acc;
      acc = 0;
      for (int p = 1; p <= n; p++) begin
         if (word[p-1]) acc = acc ^ p;
      end
      return acc;
   endfunction

   function automatic hm_result_type hamming_predict(input logic [POS_WIDTH-1:0] k_reg,
                                                     input logic act,
                                                     input logic [CW_WIDTH-1:0] pay);
      int            k;
      int            r;
      int            n;
      int            nxt;
      int            s;
      hm_result_type res;
      k = int'(k_reg);
      if (k < 1) k = 1;
      if (k > MAX_DATA_BITS) k = MAX_DATA_BITS;
      r = 0;
      while ((1 << r) < k + r + 1) r++;
      n = k + r;
      res = '0;
      res.len = POS_WIDTH'(n);
      if (act == ACT_ENCODE) begin
         nxt = 0;
         for (int p = 1; p <= n; p++) begin
            if ((p & (p - 1)) != 0) begin
               res.cw[p-1] = pay[nxt];
               nxt++;
            end
         end
         // The parity bits are the syndrome of the word holding only data.
         s = position_xor(res.cw, n);
         for (int t = 0; (1 << t) <= n; t++) begin
            if (s[t]) res.cw[(1 << t) - 1] = 1'b1;
         end
      end else begin
         res.syn = POS_WIDTH'(position_xor(pay, n));
      end
      return res;
   endfunction

   task automatic send_word(input logic act, input logic [CW_WIDTH-1:0] pay,
                            input logic typed, input hm_result_type typed_res);
      while (!steady && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {1'b0, pay};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (typed) pending_words.push_back(typed_res);
      else pending_words.push_back(hamming_predict(data_bits_cfg, act, pay));
   endtask

   // Drains the pipeline, writes data_bits and reads it back.
   task automatic set_data_bits(input logic [POS_WIDTH-1:0] value);
      logic [31:0] wdata;
      wdata = $urandom();
      wdata[POS_WIDTH-1:0] = value;
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= DATA_BITS_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data_bits_cfg = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== 32'(value)) begin
         $error("data_bits: expected %0d, actual %0d", value, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Random data to encode, or valid codewords with zero, one or two flipped positions,
   // some with junk above the codeword, or plain random words to check.
   task automatic send_random_word();
      int            pick;
      int            len;
      int            flips;
      hm_result_type clean;
      logic [30:0]   junk;
      logic [30:0]   word;
      pick = $urandom_range(99);
      word = 31'($urandom());
      if (pick < 40) begin
         send_word(ACT_ENCODE, word, PREDICTED, '0);
      end else if (pick < 85) begin
         clean = hamming_predict(data_bits_cfg, ACT_ENCODE, 31'($urandom()));
         len = int'(clean.len);
         word = clean.cw;
         flips = $urandom_range(2);
         for (int f = 0; f < flips; f++) word[$urandom_range(len - 1)] ^= 1'b1;
         if ($urandom_range(3) == 0) begin
            junk = 31'($urandom());
            junk = junk & ~((31'h1 << len) - 31'h1);
            word = word | junk;
         end
         send_word(ACT_CHECK, word, PREDICTED, '0);
      end else begin
         send_word(ACT_CHECK, word, PREDICTED, '0);
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 15);
   end

   always @(posedge clock) begin
      hm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected result transaction: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_tdata[30:0] !== want.cw) begin
               $error("codeword: expected %h, actual %h", want.cw, rsp_tdata[30:0]);
               mismatch_count++;
            end
            if (rsp_tdata[35:31] !== want.syn) begin
               $error("syndrome: expected %0d, actual %0d", want.syn, rsp_tdata[35:31]);
               mismatch_count++;
            end
            if (rsp_tdata[40:36] !== want.len) begin
               $error("total_bits: expected %0d, actual %0d", want.len, rsp_tdata[40:36]);
               mismatch_count++;
            end
         end
      end
   end

   // Ends the run when no transaction of any kind completes for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [POS_WIDTH-1:0] setting;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg != data_bits_cfg) set_data_bits(directed_rows[i].cfg);
         send_word(directed_rows[i].act, directed_rows[i].pay, directed_rows[i].typed,
                   directed_rows[i].res);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               setting = 5'd1;
            end
            1: begin
               setting = 5'd26;
            end
            2: begin
               setting = 5'd0;
            end
            3: begin
               setting = 5'd31;
            end
            4: begin
               setting = 5'd27;
            end
            default: begin
               setting = POS_WIDTH'($urandom_range(31));
            end
         endcase
         set_data_bits(setting);
         steady = (phase == 5);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_word();
      end

      req_tvalid <= 1'b0;
      steady = 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
